>>> src/b32e_pkg.sv
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and the symbol mapping of the base32 byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b32e_pkg;

  localparam int unsigned SymW     = 5;
  localparam int unsigned AsciiW   = 7;
  localparam int unsigned MaxSyms  = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [AsciiW-1:0] AsciiUpperA = 7'h41;
  localparam logic [AsciiW-1:0] AsciiDigit2 = 7'h32;
  localparam logic [SymW-1:0]   LetterCount = 5'd26;

  // One decoded byte: up to three 5-bit symbol indices, in emission order.
  typedef struct packed {
    logic [MaxSyms-1:0][SymW-1:0] idx;
    logic [1:0]                   num;
    logic                         msg_last;
  } job_t;

  function automatic logic [AsciiW-1:0] sym_to_ascii(input logic [SymW-1:0] idx);
    logic [AsciiW-1:0] res;
    if (idx < LetterCount) begin
      res = AsciiUpperA + {2'b00, idx};
    end else begin
      res = AsciiDigit2 + {2'b00, idx - LetterCount};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/b32e_front.sv
// ----------------------------------------------------------------------------
// b32e_front
// Accepts bytes, merges them with the pending bits and splits them into jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     in_byte_i,
  input  wire logic           in_last_i,
  input  wire logic           q_full_i,
  output logic                q_push_o,
  output b32e_pkg::job_t      q_job_o
);

  logic [3:0]  acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [11:0] word;
  logic [3:0]  total;
  logic        two_full;
  logic [2:0]  rem;
  logic [3:0]  rem_mask;
  logic [3:0]  left;
  logic [b32e_pkg::SymW-1:0] sym0, sym1, pad;
  logic        fire;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && !q_full_i;
  assign q_push_o   = fire;

  always_comb begin
    word     = {acc_q, in_byte_i} & {4'((5'd1 << cnt_q) - 5'd1), 8'hff};
    total    = 4'd8 + {1'b0, cnt_q};
    two_full = (total >= 4'd10);
    sym0     = 5'(word >> (total - 4'd5));
    sym1     = 5'(word >> (total - 4'd10));
    rem      = two_full ? 3'(total - 4'd10) : 3'(total - 4'd5);
    rem_mask = 4'((5'd1 << rem) - 5'd1);
    left     = word[3:0] & rem_mask;
    pad      = 5'({1'b0, left} << (3'd5 - rem));

    q_job_o          = '0;
    q_job_o.msg_last = in_last_i;
    q_job_o.idx[0]   = sym0;
    if (two_full) begin
      q_job_o.idx[1] = sym1;
      q_job_o.idx[2] = pad;
      q_job_o.num    = (in_last_i && (rem != 3'd0)) ? 2'd3 : 2'd2;
    end else begin
      q_job_o.idx[1] = pad;
      q_job_o.idx[2] = pad;
      q_job_o.num    = (in_last_i && (rem != 3'd0)) ? 2'd2 : 2'd1;
    end

    acc_d = acc_q;
    cnt_d = cnt_q;
    if (fire) begin
      acc_d = in_last_i ? 4'd0 : left;
      cnt_d = in_last_i ? 3'd0 : rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("pending bit count out of range");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_i |=> cnt_q == 3'd0)
    else $error("state not cleared after message end");
`endif

endmodule

`default_nettype wire

>>> src/b32e_queue.sv
// ----------------------------------------------------------------------------
// b32e_queue
// Short job queue that decouples the byte front end from the symbol back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire b32e_pkg::job_t push_job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                nonempty_o,
  output b32e_pkg::job_t      pop_job_o
);

  b32e_pkg::job_t mem_q [b32e_pkg::QueueDepth];
  logic [b32e_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [b32e_pkg::QueueCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == b32e_pkg::QueueCntW'(b32e_pkg::QueueDepth));
  assign nonempty_o = (cnt_q != '0);
  assign pop_job_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == b32e_pkg::QueuePtrW'(b32e_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == b32e_pkg::QueuePtrW'(b32e_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/b32e_back.sv
// ----------------------------------------------------------------------------
// b32e_back
// Takes jobs from the queue; one base32 character per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_nonempty_i,
  input  wire b32e_pkg::job_t                q_job_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [b32e_pkg::AsciiW-1:0]        out_symbol_o,
  output logic                               out_run_end_o,
  output logic                               out_msg_end_o
);

  b32e_pkg::job_t job_q;
  logic           job_valid_q;
  logic [1:0]     pos_q;
  logic           advance;
  logic           last_pos;
  logic           emit;

  logic                        out_valid_q;
  logic [b32e_pkg::AsciiW-1:0] out_symbol_q;
  logic                        out_rend_q, out_mend_q;

  assign advance  = !out_valid_q || out_ready_i;
  assign last_pos = (pos_q == job_q.num - 2'd1);
  assign emit     = advance && job_valid_q;
  assign q_pop_o  = q_nonempty_i && (!job_valid_q || (emit && last_pos));

  assign out_valid_o   = out_valid_q;
  assign out_symbol_o  = out_symbol_q;
  assign out_run_end_o = out_rend_q;
  assign out_msg_end_o = out_mend_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
    end
    if (emit) begin
      out_symbol_q <= b32e_pkg::sym_to_ascii(job_q.idx[pos_q]);
      out_rend_q   <= last_pos;
      out_mend_q   <= last_pos && job_q.msg_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= job_valid_q;
      end
      if (q_pop_o) begin
        job_valid_q <= 1'b1;
        pos_q       <= '0;
      end else if (emit) begin
        if (last_pos) begin
          job_valid_q <= 1'b0;
          pos_q       <= '0;
        end else begin
          pos_q <= pos_q + 2'd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_job_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> job_q.num != 2'd0)
    else $error("job without characters");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> pos_q < job_q.num)
    else $error("character position past end of job");
  a_mend_rend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_mend_q |-> out_rend_q)
    else $error("message end without run end");
`endif

endmodule

`default_nettype wire

>>> src/base32_byte_encoder_core.sv
// ----------------------------------------------------------------------------
// base32_byte_encoder_core
// Unpadded base32 encoder: bytes in, ASCII characters A-Z and 2-7 out.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tdata              | tlast        | tuser
//  s_axis   | in        | [7:0] data_byte    | end_of_msg   | -
//  m_axis   | out       | [6:0] symbol, [7]0 | message_end  | run_end
//
//  Each byte yields one to three characters, one character per cycle while
//  the output is not stalled. The first character of a byte is offered only
//  after it has passed the job queue, the back end's job register and its
//  output register. A two-entry job queue lets the input side keep taking
//  bytes while the output is stalled, until the queue is full. Reset clears
//  the pending bits, the queue and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module base32_byte_encoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [6:0] symbol, [7] zero
  output logic            m_axis_tlast,
  output logic            m_axis_tuser    // [0] run_end
);

  b32e_pkg::job_t push_job, pop_job;
  logic push, pop, full, nonempty;
  logic [b32e_pkg::AsciiW-1:0] symbol;

  b32e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_job_o    (push_job)
  );

  b32e_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .pop_job_o  (pop_job)
  );

  b32e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_nonempty_i  (nonempty),
    .q_job_i       (pop_job),
    .q_pop_o       (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_symbol_o  (symbol),
    .out_run_end_o (m_axis_tuser),
    .out_msg_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, symbol};

endmodule

`default_nettype wire
